>>> rtl/spdg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spdg_pkg;

  // Default sizing of the vertex store and of one edge weight
  localparam int unsigned DEF_MAX_VERTICES = 64;
  localparam int unsigned DEF_WEIGHT_BITS  = 16;

  // Fixed port widths
  localparam int unsigned VERTEX_BITS    = 6;
  localparam int unsigned WEIGHT_IN_BITS = 16;
  localparam int unsigned COUNT_BITS     = 7;
  localparam int unsigned DIST_OUT_BITS  = 22;

  localparam logic [COUNT_BITS-1:0]    VERTEX_COUNT_RESET = 7'd64;
  localparam logic [DIST_OUT_BITS-1:0] DIST_OUT_MAX       = 22'h3FFFFF;

  // Command codes of an input transaction
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_RUN   = 1'b1
  } cmd_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT_ISSUE,
    ST_OUT_LOAD
  } state_e;

endpackage

`default_nettype wire

>>> rtl/spdg_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module spdg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/shortest_path_dense_graph_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Single-source shortest path over a dense adjacency matrix held in an on-chip RAM
// (weight zero means no edge). A write transaction stores one weight.
// A run transaction searches from the given source over the first V vertices
// (V from the vertex_count register, 0 read as 1, capped at MAX_VERTICES) and then
// delivers V result transactions, vertex 0 first, with last set on vertex V-1.
// A run occupies the block for table set-up, up to V-1 search rounds (each streams one
// matrix row and the distance table through a single add and compare unit, which
// also selects the next vertex) and then the result delivery; the input is not
// ready during that time. After reset the matrix RAM is swept to zero, one word a
// cycle, over all 2**(2*ceil(log2(MAX_VERTICES))) words (4096 at the default size)
// before the first transaction is taken.
// Register writes are taken at any time but must only be issued while idle.

module shortest_path_dense_graph_core #(
  parameter int unsigned MAX_VERTICES = spdg_pkg::DEF_MAX_VERTICES,
  parameter int unsigned WEIGHT_BITS  = spdg_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration
  input  wire logic                                 cfg_we_i,
  input  wire logic [spdg_pkg::COUNT_BITS-1:0]      cfg_wdata_i,
  // input channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 command_i,
  input  wire logic [spdg_pkg::VERTEX_BITS-1:0]     from_vertex_i,
  input  wire logic [spdg_pkg::VERTEX_BITS-1:0]     to_vertex_i,
  input  wire logic [spdg_pkg::WEIGHT_IN_BITS-1:0]  weight_i,
  input  wire logic [spdg_pkg::VERTEX_BITS-1:0]     source_i,
  // output channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic      [spdg_pkg::VERTEX_BITS-1:0]     vertex_o,
  output logic      [spdg_pkg::DIST_OUT_BITS-1:0]   distance_o,
  output logic                                      reachable_o,
  output logic                                      last_o
);

  localparam int unsigned VW     = $clog2(MAX_VERTICES);
  localparam int unsigned CW     = VW + 1;
  localparam int unsigned DW     = WEIGHT_BITS + VW;
  localparam int unsigned EAW    = 2 * VW;
  localparam int unsigned EDEPTH = 1 << EAW;

  spdg_pkg::state_e state_q, state_d;

  logic [spdg_pkg::COUNT_BITS-1:0] vcount_q;
  logic [CW-1:0]                   n_eff;
  logic [CW-1:0]                   n_q;
  logic [VW-1:0]                   src_q;
  logic                            src_ok_q;
  logic [CW-1:0]                   idx_q, idx_d;
  logic [CW-1:0]                   round_q;
  logic [EAW-1:0]                  clr_q;
  logic [MAX_VERTICES-1:0]         done_q;
  logic [VW-1:0]                   u_q;
  logic [DW-1:0]                   du_q;
  logic                            uvalid_q;
  logic                            s1_valid_q;
  logic [VW-1:0]                   s1_v_q;
  logic                            best_any_q, best_any_d;
  logic                            best_valid_q, best_valid_d;
  logic [DW-1:0]                   best_dist_q, best_dist_d;
  logic [VW-1:0]                   best_idx_q, best_idx_d;
  logic                            out_valid_q;
  logic [spdg_pkg::VERTEX_BITS-1:0]   out_vertex_q;
  logic [spdg_pkg::DIST_OUT_BITS-1:0] out_distance_q;
  logic                            out_reachable_q;
  logic                            out_last_q;

  logic in_accept, is_run, wr_ok, src_ok, idx_last, more_rounds;
  logic [31:0]            weight_ext;

  // RAM ports
  logic                   edge_we;
  logic [EAW-1:0]         edge_waddr, edge_raddr;
  logic [WEIGHT_BITS-1:0] edge_wdata, edge_rdata;
  logic                   dist_we;
  logic [VW-1:0]          dist_waddr, dist_raddr;
  logic [DW:0]            dist_wdata, dist_rdata;

  // Relax and select unit
  logic [DW-1:0] dv, cand, new_dist, od;
  logic          dvalid, v_done, relax, new_valid, take, sat;

  // Effective vertex count
  always_comb begin
    if (vcount_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(vcount_q) > MAX_VERTICES) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(vcount_q);
    end
  end

  assign in_ready_o  = (state_q == spdg_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign is_run      = (command_i == spdg_pkg::CMD_RUN);
  assign wr_ok       = (32'(from_vertex_i) < MAX_VERTICES) && (32'(to_vertex_i) < MAX_VERTICES);
  assign src_ok      = 32'(source_i) < 32'(n_eff);
  assign weight_ext  = 32'(weight_i);
  assign idx_last    = (idx_q + CW'(1)) == n_q;
  assign more_rounds = (round_q + CW'(2)) < n_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spdg_pkg::ST_CLEAR: begin
        if (&clr_q) state_d = spdg_pkg::ST_IDLE;
      end
      spdg_pkg::ST_IDLE: begin
        if (in_accept && is_run) state_d = spdg_pkg::ST_INIT;
      end
      spdg_pkg::ST_INIT: begin
        if (idx_last) begin
          if (src_ok_q && (n_q > CW'(1))) state_d = spdg_pkg::ST_SCAN;
          else                            state_d = spdg_pkg::ST_OUT_ISSUE;
        end
      end
      spdg_pkg::ST_SCAN: begin
        if (idx_last) state_d = spdg_pkg::ST_DRAIN;
      end
      spdg_pkg::ST_DRAIN: begin
        if (more_rounds) state_d = spdg_pkg::ST_SCAN;
        else             state_d = spdg_pkg::ST_OUT_ISSUE;
      end
      spdg_pkg::ST_OUT_ISSUE: begin
        if (!out_valid_q || out_ready_i) state_d = spdg_pkg::ST_OUT_LOAD;
      end
      spdg_pkg::ST_OUT_LOAD: begin
        if (idx_last) state_d = spdg_pkg::ST_IDLE;
        else          state_d = spdg_pkg::ST_OUT_ISSUE;
      end
      default: state_d = spdg_pkg::ST_IDLE;
    endcase
  end

  // Relax the streamed vertex and keep the best unvisited candidate
  always_comb begin
    dv        = dist_rdata[DW-1:0];
    dvalid    = dist_rdata[DW];
    cand      = du_q + DW'(edge_rdata);
    v_done    = done_q[s1_v_q];
    relax     = s1_valid_q && uvalid_q && !v_done && (edge_rdata != '0) &&
                (!dvalid || (cand < dv));
    new_valid = relax || dvalid;
    new_dist  = relax ? cand : dv;
    take      = s1_valid_q && !v_done &&
                (!best_any_q || (new_valid ? (!best_valid_q || (new_dist <= best_dist_q))
                                           : !best_valid_q));
    best_any_d   = best_any_q || take;
    best_valid_d = take ? new_valid : best_valid_q;
    best_dist_d  = take ? new_dist  : best_dist_q;
    best_idx_d   = take ? s1_v_q    : best_idx_q;
  end

  // Sequencer outputs: RAM ports and counter steps
  always_comb begin
    edge_we    = 1'b0;
    edge_waddr = {from_vertex_i[VW-1:0], to_vertex_i[VW-1:0]};
    edge_wdata = weight_ext[WEIGHT_BITS-1:0];
    edge_raddr = {u_q, idx_q[VW-1:0]};
    dist_we    = relax;
    dist_waddr = s1_v_q;
    dist_wdata = {1'b1, cand};
    dist_raddr = idx_q[VW-1:0];
    idx_d      = idx_q;
    unique case (state_q)
      spdg_pkg::ST_CLEAR: begin
        edge_we    = 1'b1;
        edge_waddr = clr_q;
        edge_wdata = '0;
      end
      spdg_pkg::ST_IDLE: begin
        edge_we = in_accept && !is_run && wr_ok;
        idx_d   = '0;
      end
      spdg_pkg::ST_INIT: begin
        dist_we    = 1'b1;
        dist_waddr = idx_q[VW-1:0];
        dist_wdata = {src_ok_q && (idx_q[VW-1:0] == src_q), {DW{1'b0}}};
        idx_d      = idx_last ? '0 : idx_q + CW'(1);
      end
      spdg_pkg::ST_SCAN: begin
        idx_d = idx_last ? '0 : idx_q + CW'(1);
      end
      spdg_pkg::ST_DRAIN: begin
        idx_d = '0;
      end
      spdg_pkg::ST_OUT_ISSUE: begin
        idx_d = idx_q;
      end
      spdg_pkg::ST_OUT_LOAD: begin
        idx_d = idx_q + CW'(1);
      end
      default: idx_d = idx_q;
    endcase
  end

  // Saturate the reported distance
  assign od  = dist_rdata[DW-1:0];
  assign sat = 64'(od) > 64'(spdg_pkg::DIST_OUT_MAX);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spdg_pkg::ST_CLEAR;
      vcount_q    <= spdg_pkg::VERTEX_COUNT_RESET;
      clr_q       <= '0;
      idx_q       <= '0;
      round_q     <= '0;
      done_q      <= '0;
      s1_valid_q  <= 1'b0;
      best_any_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      s1_valid_q <= (state_q == spdg_pkg::ST_SCAN);
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      if (state_q == spdg_pkg::ST_CLEAR) clr_q <= clr_q + EAW'(1);
      // start a run with nothing visited
      if (state_q == spdg_pkg::ST_IDLE && in_accept && is_run) begin
        done_q  <= '0;
        round_q <= '0;
      end
      // the source opens the first round
      if (state_q == spdg_pkg::ST_INIT && idx_last && src_ok_q) begin
        done_q[src_q] <= 1'b1;
      end
      // take the best candidate into the next round
      if (state_q == spdg_pkg::ST_DRAIN) begin
        round_q <= round_q + CW'(1);
        if (more_rounds) done_q[best_idx_d] <= 1'b1;
      end
      // clear the selection outside a scan
      if (state_q == spdg_pkg::ST_SCAN) best_any_q <= best_any_d;
      else                              best_any_q <= 1'b0;
      // hold a result until taken
      if (state_q == spdg_pkg::ST_OUT_LOAD) out_valid_q <= 1'b1;
      else if (out_ready_i)                 out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == spdg_pkg::ST_IDLE && in_accept && is_run) begin
      n_q      <= n_eff;
      src_q    <= source_i[VW-1:0];
      src_ok_q <= src_ok;
    end
    if (state_q == spdg_pkg::ST_INIT) begin
      u_q      <= src_q;
      du_q     <= '0;
      uvalid_q <= 1'b1;
    end
    if (state_q == spdg_pkg::ST_DRAIN) begin
      u_q      <= best_idx_d;
      du_q     <= best_dist_d;
      uvalid_q <= best_valid_d;
    end
    s1_v_q       <= idx_q[VW-1:0];
    best_valid_q <= best_valid_d;
    best_dist_q  <= best_dist_d;
    best_idx_q   <= best_idx_d;
    if (state_q == spdg_pkg::ST_OUT_LOAD) begin
      out_vertex_q    <= spdg_pkg::VERTEX_BITS'(idx_q[VW-1:0]);
      out_reachable_q <= dist_rdata[DW];
      out_last_q      <= idx_last;
      if (!dist_rdata[DW]) out_distance_q <= '0;
      else if (sat)        out_distance_q <= spdg_pkg::DIST_OUT_MAX;
      else                 out_distance_q <= spdg_pkg::DIST_OUT_BITS'(od);
    end
  end

  assign out_valid_o = out_valid_q;
  assign vertex_o    = out_vertex_q;
  assign distance_o  = out_distance_q;
  assign reachable_o = out_reachable_q;
  assign last_o      = out_last_q;

  // Adjacency matrix
  spdg_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (EDEPTH)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  // Distance table: valid flag over distance
  spdg_ram #(
    .WIDTH (DW + 1),
    .DEPTH (1 << VW)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rdata)
  );

  // A relaxation never touches a vertex already settled
  a_relax_unsettled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dist_we && (state_q != spdg_pkg::ST_INIT)) |-> !done_q[dist_waddr])
    else $error("relaxation wrote a settled vertex");

  // Each new round starts from a vertex not yet settled
  a_pick_unsettled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == spdg_pkg::ST_DRAIN) && more_rounds) |->
      (best_any_d && !done_q[best_idx_d]))
    else $error("next round picked no vertex or a settled one");

  // An unreachable vertex reports distance zero
  a_unreach_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !reachable_o) |-> (distance_o == '0))
    else $error("unreachable vertex with non-zero distance");

endmodule

`default_nettype wire
